### design/tvec_pkg.sv
// ----------------------------------------------------------------------------
// tvec_pkg
// Shared types and constants for the per-triangle tangent block.
// ----------------------------------------------------------------------------
package tvec_pkg;

    localparam int PW   = 32;   // position width, Q16.16
    localparam int TW   = 24;   // texcoord width, Q8.16
    localparam int DPW  = PW + 1;
    localparam int DTW  = TW + 1;
    localparam int DETW = 2 * DTW + 1;
    localparam int WW   = DPW + DTW + 1;
    localparam int MAW  = 34;   // multiplier operand a
    localparam int MBW  = 31;   // multiplier operand b
    localparam int PRW  = 64;   // stored product
    localparam int NW   = 30;   // normalized magnitude width
    localparam int SW   = 2 * NW + 2;
    localparam int LW   = SW / 2;
    localparam int QW   = 16;
    localparam int FRAC = 15;
    localparam int NUMW = NW + FRAC + 1;
    localparam int RQW  = LW + 2;

    localparam int NORM_HI  = 30;
    localparam int NORM_LO  = 29;
    localparam int NORM_BIG = 8;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] SLOT_LAST = 2'd2;
    localparam logic [1:0] COMP_LAST = 2'd2;

    localparam logic [4:0] MUL_LAST  = 5'd8;
    localparam logic [4:0] SQ_LAST   = 5'd3;
    localparam logic [4:0] SQRT_LAST = 5'(LW - 1);
    localparam logic [4:0] DIV_LAST  = 5'(QW);

    localparam logic signed [QW-1:0] SAT_MAX = 16'sd32767;

    typedef struct packed {
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] pos_z;
        logic signed [TW-1:0] tex_u;
        logic signed [TW-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [QW-1:0] tan_x;
        logic signed [QW-1:0] tan_y;
        logic signed [QW-1:0] tan_z;
        logic                 degenerate_uv;
        logic                 zero_tangent;
        logic                 last_of_triangle;
    } result_t;

    typedef struct packed {
        logic signed [DPW-1:0] dp1_x;
        logic signed [DPW-1:0] dp1_y;
        logic signed [DPW-1:0] dp1_z;
        logic signed [DPW-1:0] dp2_x;
        logic signed [DPW-1:0] dp2_y;
        logic signed [DPW-1:0] dp2_z;
        logic signed [DTW-1:0] du1;
        logic signed [DTW-1:0] dv1;
        logic signed [DTW-1:0] du2;
        logic signed [DTW-1:0] dv2;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_MAG,
        BK_MAX,
        BK_NORM,
        BK_SQ,
        BK_SQRT,
        BK_DIV,
        BK_EMIT
    } back_state_t;

endpackage

### design/tvec_front.sv
// ----------------------------------------------------------------------------
// tvec_front
// Groups vertices in threes and forms position and texcoord deltas.
// ----------------------------------------------------------------------------
module tvec_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  tvec_pkg::vertex_t vertex,
    output logic              push,
    output tvec_pkg::job_t    push_job,
    input  logic              queue_full
);

    logic [1:0]        slot_reg;
    logic [1:0]        slot_next;
    tvec_pkg::vertex_t held_reg [2];
    logic              accept;

    assign vertex_stall = (slot_reg == tvec_pkg::SLOT_LAST) && queue_full;
    assign accept       = vertex_valid && !vertex_stall;
    assign push         = accept && (slot_reg == tvec_pkg::SLOT_LAST);

    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
        begin
            slot_next = (slot_reg == tvec_pkg::SLOT_LAST) ? 2'd0 : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (slot_reg != tvec_pkg::SLOT_LAST))
        begin
            held_reg[slot_reg[0]] <= vertex;
        end
    end

    always_comb
    begin
        push_job.dp1_x = {held_reg[1].pos_x[31], held_reg[1].pos_x}
                       - {held_reg[0].pos_x[31], held_reg[0].pos_x};
        push_job.dp1_y = {held_reg[1].pos_y[31], held_reg[1].pos_y}
                       - {held_reg[0].pos_y[31], held_reg[0].pos_y};
        push_job.dp1_z = {held_reg[1].pos_z[31], held_reg[1].pos_z}
                       - {held_reg[0].pos_z[31], held_reg[0].pos_z};
        push_job.dp2_x = {vertex.pos_x[31], vertex.pos_x}
                       - {held_reg[0].pos_x[31], held_reg[0].pos_x};
        push_job.dp2_y = {vertex.pos_y[31], vertex.pos_y}
                       - {held_reg[0].pos_y[31], held_reg[0].pos_y};
        push_job.dp2_z = {vertex.pos_z[31], vertex.pos_z}
                       - {held_reg[0].pos_z[31], held_reg[0].pos_z};
        push_job.du1   = {held_reg[1].tex_u[23], held_reg[1].tex_u}
                       - {held_reg[0].tex_u[23], held_reg[0].tex_u};
        push_job.dv1   = {held_reg[1].tex_v[23], held_reg[1].tex_v}
                       - {held_reg[0].tex_v[23], held_reg[0].tex_v};
        push_job.du2   = {vertex.tex_u[23], vertex.tex_u}
                       - {held_reg[0].tex_u[23], held_reg[0].tex_u};
        push_job.dv2   = {vertex.tex_v[23], vertex.tex_v}
                       - {held_reg[0].tex_v[23], held_reg[0].tex_v};
    end

endmodule

### design/tvec_fifo.sv
// ----------------------------------------------------------------------------
// tvec_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module tvec_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tvec_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tvec_pkg::job_t pop_job
);

    tvec_pkg::job_t          mem [tvec_pkg::QDEPTH];
    logic [tvec_pkg::QAW-1:0] wr_ptr_reg;
    logic [tvec_pkg::QAW-1:0] rd_ptr_reg;
    logic [tvec_pkg::QAW:0]   count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign full      = (count_reg == (tvec_pkg::QAW+1)'(tvec_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tvec_pkg::QAW'(tvec_pkg::QDEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tvec_pkg::QAW'(tvec_pkg::QDEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### design/tvec_back.sv
// ----------------------------------------------------------------------------
// tvec_back
// Sequencer for determinant sign, tangent, normalization, square root,
// per-component division and result output.
// ----------------------------------------------------------------------------
module tvec_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  tvec_pkg::job_t    job,
    output logic              job_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output tvec_pkg::result_t result
);

    tvec_pkg::back_state_t state_reg;
    tvec_pkg::back_state_t state_next;
    logic [4:0]            step_reg;
    logic [4:0]            step_next;
    logic [1:0]            comp_idx_reg;
    logic [1:0]            emit_cnt_reg;

    tvec_pkg::job_t        job_reg;
    logic signed [tvec_pkg::MAW-1:0]  mul_a;
    logic signed [tvec_pkg::MBW-1:0]  mul_b;
    logic signed [tvec_pkg::MAW+tvec_pkg::MBW-1:0] mul_full;
    logic signed [tvec_pkg::PRW-1:0]  prod_reg;

    logic signed [tvec_pkg::DETW-1:0] det_reg;
    logic signed [tvec_pkg::WW-1:0]   w_reg [3];
    logic [tvec_pkg::WW-1:0]          mag_reg [3];
    logic [tvec_pkg::WW-1:0]          m_reg;
    logic [2:0]                       neg_reg;
    logic                             degen_reg;
    logic                             flip_reg;
    logic                             zero_reg;

    logic [tvec_pkg::SW-1:0]          s_reg;
    logic [tvec_pkg::RQW-1:0]         sq_rem_reg;
    logic [tvec_pkg::LW-1:0]          root_reg;
    logic [tvec_pkg::RQW+1:0]         sq_rem2;
    logic [tvec_pkg::RQW-1:0]         sq_trial;
    logic                             sq_ge;

    logic [tvec_pkg::LW-1:0]          dv_rem_reg;
    logic [tvec_pkg::QW-1:0]          dv_low_reg;
    logic [tvec_pkg::QW-1:0]          dv_q_reg;
    logic [tvec_pkg::LW:0]            dv_rem2;
    logic                             dv_ge;
    logic [tvec_pkg::QW-1:0]          dv_qn;
    logic [tvec_pkg::NUMW-1:0]        dv_num;

    logic signed [tvec_pkg::QW-1:0]   comp_reg [3];
    logic                             out_valid_reg;
    tvec_pkg::result_t                out_reg;

    logic norm_hi;
    logic norm_hi_big;
    logic norm_lo;
    logic norm_lo_big;
    logic div_done;
    logic emit_load;
    logic [2:0] w_neg;

    assign norm_hi     = |m_reg[tvec_pkg::WW-1:tvec_pkg::NORM_HI];
    assign norm_hi_big = |m_reg[tvec_pkg::WW-1:tvec_pkg::NORM_HI+tvec_pkg::NORM_BIG];
    assign norm_lo     = ~|m_reg[tvec_pkg::WW-1:tvec_pkg::NORM_LO];
    assign norm_lo_big = ~|m_reg[tvec_pkg::WW-1:tvec_pkg::NORM_LO-tvec_pkg::NORM_BIG];

    assign w_neg = {w_reg[2][tvec_pkg::WW-1], w_reg[1][tvec_pkg::WW-1],
                    w_reg[0][tvec_pkg::WW-1]};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == tvec_pkg::BK_MUL)
        begin
            unique case (step_reg[2:0])
                3'd0:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.du1);
                    mul_b = tvec_pkg::MBW'(job_reg.dv2);
                end
                3'd1:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dv1);
                    mul_b = tvec_pkg::MBW'(job_reg.du2);
                end
                3'd2:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp1_x);
                    mul_b = tvec_pkg::MBW'(job_reg.dv2);
                end
                3'd3:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp2_x);
                    mul_b = tvec_pkg::MBW'(job_reg.dv1);
                end
                3'd4:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp1_y);
                    mul_b = tvec_pkg::MBW'(job_reg.dv2);
                end
                3'd5:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp2_y);
                    mul_b = tvec_pkg::MBW'(job_reg.dv1);
                end
                3'd6:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp1_z);
                    mul_b = tvec_pkg::MBW'(job_reg.dv2);
                end
                default:
                begin
                    mul_a = tvec_pkg::MAW'(job_reg.dp2_z);
                    mul_b = tvec_pkg::MBW'(job_reg.dv1);
                end
            endcase
        end
        else if (step_reg[1:0] != 2'd3)
        begin
            mul_a = $signed({4'd0, mag_reg[step_reg[1:0]][tvec_pkg::NW-1:0]});
            mul_b = $signed({1'b0, mag_reg[step_reg[1:0]][tvec_pkg::NW-1:0]});
        end
    end

    assign mul_full = mul_a * mul_b;

    // square root digit step
    assign sq_rem2  = {sq_rem_reg, s_reg[tvec_pkg::SW-1:tvec_pkg::SW-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= {2'b00, sq_trial};

    // division bit step
    assign dv_num  = {1'b0, mag_reg[comp_idx_reg][tvec_pkg::NW-1:0], {tvec_pkg::FRAC{1'b0}}}
                   + {{(tvec_pkg::NUMW-tvec_pkg::LW+1){1'b0}}, root_reg[tvec_pkg::LW-1:1]};
    assign dv_rem2 = {dv_rem_reg, dv_low_reg[tvec_pkg::QW-1]};
    assign dv_ge   = dv_rem2 >= {1'b0, root_reg};
    assign dv_qn   = {dv_q_reg[tvec_pkg::QW-2:0], dv_ge};
    assign div_done = (state_reg == tvec_pkg::BK_DIV) && (step_reg == tvec_pkg::DIV_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tvec_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = tvec_pkg::BK_MUL;
                end
            end
            tvec_pkg::BK_MUL:
            begin
                if (step_reg == tvec_pkg::MUL_LAST)
                begin
                    state_next = tvec_pkg::BK_MAG;
                end
            end
            tvec_pkg::BK_MAG:
            begin
                state_next = tvec_pkg::BK_MAX;
            end
            tvec_pkg::BK_MAX:
            begin
                state_next = tvec_pkg::BK_NORM;
            end
            tvec_pkg::BK_NORM:
            begin
                if (m_reg == '0)
                begin
                    state_next = tvec_pkg::BK_EMIT;
                end
                else if (!norm_hi && !norm_lo)
                begin
                    state_next = tvec_pkg::BK_SQ;
                end
            end
            tvec_pkg::BK_SQ:
            begin
                if (step_reg == tvec_pkg::SQ_LAST)
                begin
                    state_next = tvec_pkg::BK_SQRT;
                end
            end
            tvec_pkg::BK_SQRT:
            begin
                if (step_reg == tvec_pkg::SQRT_LAST)
                begin
                    state_next = tvec_pkg::BK_DIV;
                end
            end
            tvec_pkg::BK_DIV:
            begin
                if (div_done && (comp_idx_reg == tvec_pkg::COMP_LAST))
                begin
                    state_next = tvec_pkg::BK_EMIT;
                end
            end
            tvec_pkg::BK_EMIT:
            begin
                if (emit_load && (emit_cnt_reg == tvec_pkg::COMP_LAST))
                begin
                    state_next = tvec_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tvec_pkg::BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        job_pop   = (state_reg == tvec_pkg::BK_IDLE) && job_valid;
        emit_load = (state_reg == tvec_pkg::BK_EMIT) && (!out_valid_reg || !result_stall);
        step_next = (state_next != state_reg || div_done) ? 5'd0 : step_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvec_pkg::BK_IDLE;
            step_reg      <= 5'd0;
            comp_idx_reg  <= 2'd0;
            emit_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (job_pop)
            begin
                comp_idx_reg <= 2'd0;
                emit_cnt_reg <= 2'd0;
            end
            else
            begin
                if (div_done)
                begin
                    comp_idx_reg <= comp_idx_reg + 2'd1;
                end
                if (emit_load)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 2'd1;
                end
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[tvec_pkg::PRW-1:0];
        if (job_pop)
        begin
            job_reg <= job;
        end
        unique case (state_reg)
            tvec_pkg::BK_MUL:
            begin
                unique case (step_reg[3:0])
                    4'd1: det_reg  <= prod_reg[tvec_pkg::DETW-1:0];
                    4'd2: det_reg  <= det_reg - prod_reg[tvec_pkg::DETW-1:0];
                    4'd3: w_reg[0] <= prod_reg[tvec_pkg::WW-1:0];
                    4'd4: w_reg[0] <= w_reg[0] - prod_reg[tvec_pkg::WW-1:0];
                    4'd5: w_reg[1] <= prod_reg[tvec_pkg::WW-1:0];
                    4'd6: w_reg[1] <= w_reg[1] - prod_reg[tvec_pkg::WW-1:0];
                    4'd7: w_reg[2] <= prod_reg[tvec_pkg::WW-1:0];
                    4'd8: w_reg[2] <= w_reg[2] - prod_reg[tvec_pkg::WW-1:0];
                    default: ;
                endcase
            end
            tvec_pkg::BK_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= w_neg[i] ? -w_reg[i] : w_reg[i];
                end
                neg_reg   <= w_neg;
                degen_reg <= (det_reg == '0);
                flip_reg  <= det_reg[tvec_pkg::DETW-1];
            end
            tvec_pkg::BK_MAX:
            begin
                if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2])
                begin
                    m_reg <= mag_reg[0];
                end
                else if (mag_reg[1] >= mag_reg[2])
                begin
                    m_reg <= mag_reg[1];
                end
                else
                begin
                    m_reg <= mag_reg[2];
                end
            end
            tvec_pkg::BK_NORM:
            begin
                zero_reg <= (m_reg == '0);
                if (m_reg == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        comp_reg[i] <= '0;
                    end
                end
                else if (norm_hi_big)
                begin
                    m_reg <= m_reg >> tvec_pkg::NORM_BIG;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> tvec_pkg::NORM_BIG;
                    end
                end
                else if (norm_hi)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (norm_lo_big)
                begin
                    m_reg <= m_reg << tvec_pkg::NORM_BIG;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << tvec_pkg::NORM_BIG;
                    end
                end
                else if (norm_lo)
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            tvec_pkg::BK_SQ:
            begin
                if (step_reg == 5'd1)
                begin
                    s_reg <= prod_reg[tvec_pkg::SW-1:0];
                end
                else if (step_reg != 5'd0)
                begin
                    s_reg <= s_reg + prod_reg[tvec_pkg::SW-1:0];
                end
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            tvec_pkg::BK_SQRT:
            begin
                s_reg <= s_reg << 2;
                if (sq_ge)
                begin
                    sq_rem_reg <= tvec_pkg::RQW'(sq_rem2 - {2'b00, sq_trial});
                    root_reg   <= {root_reg[tvec_pkg::LW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_rem2[tvec_pkg::RQW-1:0];
                    root_reg   <= {root_reg[tvec_pkg::LW-2:0], 1'b0};
                end
            end
            tvec_pkg::BK_DIV:
            begin
                if (step_reg == 5'd0)
                begin
                    dv_rem_reg <= {1'b0, dv_num[tvec_pkg::NUMW-1:tvec_pkg::QW]};
                    dv_low_reg <= dv_num[tvec_pkg::QW-1:0];
                    dv_q_reg   <= '0;
                end
                else
                begin
                    dv_rem_reg <= dv_ge ? tvec_pkg::LW'(dv_rem2 - {1'b0, root_reg})
                                        : dv_rem2[tvec_pkg::LW-1:0];
                    dv_low_reg <= dv_low_reg << 1;
                    dv_q_reg   <= dv_qn;
                end
                if (div_done)
                begin
                    if (neg_reg[comp_idx_reg] != flip_reg)
                    begin
                        comp_reg[comp_idx_reg] <= -$signed(dv_qn);
                    end
                    else if (dv_qn[tvec_pkg::QW-1])
                    begin
                        comp_reg[comp_idx_reg] <= tvec_pkg::SAT_MAX;
                    end
                    else
                    begin
                        comp_reg[comp_idx_reg] <= $signed(dv_qn);
                    end
                end
            end
            default: ;
        endcase
        if (emit_load)
        begin
            out_reg.tan_x            <= comp_reg[0];
            out_reg.tan_y            <= comp_reg[1];
            out_reg.tan_z            <= comp_reg[2];
            out_reg.degenerate_uv    <= degen_reg;
            out_reg.zero_tangent     <= zero_reg;
            out_reg.last_of_triangle <= (emit_cnt_reg == tvec_pkg::COMP_LAST);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### design/triangle_tangent_vector.sv
// ----------------------------------------------------------------------------
// triangle_tangent_vector
// The back sequencer multiplies, takes magnitudes and their maximum, normalizes, sums
// squares, takes the square root and divides each of the three components in turn;
// a zero tangent skips to output, and results follow back to back unless the output stalls.
// The back finishes one triangle before it pops the next request; the front takes
// one vertex a cycle while the two-entry request queue has room.
// Reset clears the vertex slot, queue and sequencer; a partial triangle is dropped.
// ----------------------------------------------------------------------------
module triangle_tangent_vector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  tvec_pkg::vertex_t vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output tvec_pkg::result_t result
);

    logic           push;
    tvec_pkg::job_t push_job;
    logic           queue_full;
    logic           job_valid;
    logic           job_pop;
    tvec_pkg::job_t job;

    tvec_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    tvec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_job   (job)
    );

    tvec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### design/tvec_checker.sv
// ----------------------------------------------------------------------------
// tvec_checker
// Port-level checks for the tangent block, attached by bind.
// ----------------------------------------------------------------------------
module tvec_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input tvec_pkg::result_t result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    a_zero_tangent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_tangent |->
            (result.tan_x == '0) && (result.tan_y == '0) && (result.tan_z == '0))
        else $error("zero tangent with nonzero components");

    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.zero_tangent |->
            (result.tan_x != '0) || (result.tan_y != '0) || (result.tan_z != '0))
        else $error("unit tangent is all zero");

endmodule

bind triangle_tangent_vector tvec_checker u_tvec_checker (.*);
